### hw/rtl/midpoint_subdivision_line_raster_core_assert.svh
// ----------------------------------------------------------------------------
// midpoint line raster assertion macros
// concurrent checks for the raster core, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_SUBDIVISION_LINE_RASTER_CORE_ASSERT_SVH
`define MIDPOINT_SUBDIVISION_LINE_RASTER_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define MPS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// shared constants and types of the midpoint line raster
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int COORD_BITS_DEF  = 6;
    localparam int STACK_DEPTH_DEF = 8;

    // stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

### hw/rtl/mps_if.sv
// ----------------------------------------------------------------------------
// mps channel interfaces
// valid/ready channels for segment input and pixel output beats
// ----------------------------------------------------------------------------
interface mps_seg_if #(
    parameter int COORD_BITS = mps_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

interface mps_pix_if #(
    parameter int COORD_BITS = mps_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input last_pixel, output ready);
endinterface

### hw/rtl/mps_split_unit.sv
// ----------------------------------------------------------------------------
// mps_split_unit
// midpoint split of one diagonal segment into left and right halves
// ----------------------------------------------------------------------------
module mps_split_unit #(
    parameter int COORD_BITS = mps_pkg::COORD_BITS_DEF
) (
    input  logic [4*COORD_BITS-1:0] seg,
    output logic [4*COORD_BITS-1:0] left_seg,
    output logic [4*COORD_BITS-1:0] right_seg
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] ax, ay, bx, by;
    logic [CB-1:0] lx, ly, rx, ry;
    logic [CB:0]   sx, sy;
    logic [CB-1:0] lo, hi, mid_y, top, bot;
    logic          left_high;

    assign {ax, ay, bx, by} = seg;

    always_comb
    begin
        if (bx > ax)
        begin
            lx = ax; ly = ay; rx = bx; ry = by;
        end
        else
        begin
            lx = bx; ly = by; rx = ax; ry = ay;
        end
        left_high = ly > ry;

        // x: the right half starts at floor + 1 in both the odd and the even case
        sx = {1'b0, lx} + {1'b0, rx};
        lo = sx[CB:1];
        hi = lo + 1'b1;

        sy    = {1'b0, ay} + {1'b0, by};
        mid_y = sy[CB:1];
        if (sy[0])
        begin
            bot = mid_y;
            top = mid_y + 1'b1;
        end
        else if (left_high)
        begin
            bot = mid_y - 1'b1;
            top = mid_y;
        end
        else
        begin
            bot = mid_y;
            top = mid_y + 1'b1;
        end

        left_seg  = {lx, ly, lo, (left_high ? top : bot)};
        right_seg = {hi, (left_high ? bot : top), rx, ry};
    end

endmodule

### hw/rtl/mps_seg_stack.sv
// ----------------------------------------------------------------------------
// mps_seg_stack
// pending right-half segments, one write port and one registered read port
// ----------------------------------------------------------------------------
module mps_seg_stack #(
    parameter int SEG_W       = 4 * mps_pkg::COORD_BITS_DEF,
    parameter int STACK_DEPTH = mps_pkg::STACK_DEPTH_DEF
) (
    input  logic                           clk,
    input  mps_pkg::stack_ctrl_t           ctrl,
    input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
    input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
    input  logic [SEG_W-1:0]               wr_data,
    output logic [SEG_W-1:0]               rd_data
);

    logic [SEG_W-1:0] mem [STACK_DEPTH];
    logic [SEG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/midpoint_subdivision_line_raster_core.sv
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_raster_core
// rasterizes one line segment by midpoint subdivision, one pixel per beat
// ----------------------------------------------------------------------------
// usage
//   seg channel: one beat carries the two endpoints of a segment. ready is
//   high only between segments; a segment is taken in one beat.
//   pix channel: one beat per pixel, in subdivision order; last_pixel marks
//   the final pixel of the segment.
// sequencing
//   a diagonal segment passes through S_EVAL once per split, using the
//   shared split unit; each axis-aligned run takes a setup step in S_EVAL
//   and then emits its pixels from S_RUN, and each stack pop passes
//   through S_POP for the registered stack read.
//   the next segment is taken as soon as the last pixel sits in the output
//   register, even while that beat still waits.
// reset and stall
//   reset empties the stack and drops any pending beat. when the receiver
//   stalls, the sequencer holds in S_RUN and the pixel register keeps its beat.
// ----------------------------------------------------------------------------
`include "midpoint_subdivision_line_raster_core_assert.svh"

module midpoint_subdivision_line_raster_core #(
    parameter int COORD_BITS  = mps_pkg::COORD_BITS_DEF,
    parameter int STACK_DEPTH = mps_pkg::STACK_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mps_seg_if.sink   seg,
    mps_pix_if.source pix
);

    localparam int CB          = COORD_BITS;
    localparam int SEG_W       = 4 * CB;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int MAX_RESULTS = 1 << CB;
    localparam int CNT_W       = CB + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RUN,
        S_POP
    } state_t;

    state_t             state_reg;
    logic [SEG_W-1:0]   cur_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CB-1:0]      run_pos_reg;
    logic [CB-1:0]      run_end_reg;
    logic [CB-1:0]      run_fix_reg;
    logic               run_vert_reg;
    logic               out_valid_reg;
    logic [CB-1:0]      pixel_x_reg;
    logic [CB-1:0]      pixel_y_reg;
    logic               last_pixel_reg;

    logic [CB-1:0]      ax, ay, bx, by;
    logic [CB-1:0]      run_a, run_b;
    logic               is_run, is_vert;
    logic [SEG_W-1:0]   left_seg, right_seg, pop_seg;
    logic [SP_W-1:0]    sp_dec;
    logic               slot_free, run_done, at_limit, last_beat, emit;
    mps_pkg::stack_ctrl_t stack_ctrl;

    assign {ax, ay, bx, by} = cur_reg;
    assign is_vert = (ax == bx);
    assign is_run  = is_vert || (ay == by);
    assign run_a   = is_vert ? ay : ax;
    assign run_b   = is_vert ? by : bx;

    mps_split_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_split (
        .seg       (cur_reg),
        .left_seg  (left_seg),
        .right_seg (right_seg)
    );

    assign sp_dec    = sp_reg - 1'b1;
    assign slot_free = !out_valid_reg || pix.ready;
    assign emit      = (state_reg == S_RUN) && slot_free;
    assign run_done  = (run_pos_reg == run_end_reg);
    assign at_limit  = (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign last_beat = at_limit || (run_done && (sp_reg == '0));

    // full stack drops the right half
    assign stack_ctrl.push = (state_reg == S_EVAL) && !is_run &&
                             (sp_reg < SP_W'(STACK_DEPTH));
    assign stack_ctrl.pop  = emit && run_done && !last_beat;

    mps_seg_stack #(
        .SEG_W       (SEG_W),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .ctrl    (stack_ctrl),
        .wr_addr (sp_reg[AW-1:0]),
        .rd_addr (sp_dec[AW-1:0]),
        .wr_data (right_seg),
        .rd_data (pop_seg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            sp_reg         <= '0;
            cnt_reg        <= '0;
            run_pos_reg    <= '0;
            run_end_reg    <= '0;
            run_fix_reg    <= '0;
            run_vert_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pixel_x_reg    <= '0;
            pixel_y_reg    <= '0;
            last_pixel_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && pix.ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (seg.valid)
                    begin
                        cur_reg   <= {seg.start_x, seg.start_y, seg.end_x, seg.end_y};
                        sp_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (is_run)
                    begin
                        run_pos_reg  <= (run_a < run_b) ? run_a : run_b;
                        run_end_reg  <= (run_a < run_b) ? run_b : run_a;
                        run_fix_reg  <= is_vert ? ax : ay;
                        run_vert_reg <= is_vert;
                        state_reg    <= S_RUN;
                    end
                    else
                    begin
                        cur_reg <= left_seg;
                        if (stack_ctrl.push)
                        begin
                            sp_reg <= sp_reg + 1'b1;
                        end
                    end
                end
                S_RUN:
                begin
                    if (emit)
                    begin
                        out_valid_reg  <= 1'b1;
                        pixel_x_reg    <= run_vert_reg ? run_fix_reg : run_pos_reg;
                        pixel_y_reg    <= run_vert_reg ? run_pos_reg : run_fix_reg;
                        last_pixel_reg <= last_beat;
                        cnt_reg        <= cnt_reg + 1'b1;
                        if (last_beat)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (run_done)
                        begin
                            sp_reg    <= sp_dec;
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            run_pos_reg <= run_pos_reg + 1'b1;
                        end
                    end
                end
                S_POP:
                begin
                    // stack read data lands this cycle
                    cur_reg   <= pop_seg;
                    state_reg <= S_EVAL;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign seg.ready      = (state_reg == S_IDLE);
    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = pixel_x_reg;
    assign pix.pixel_y    = pixel_y_reg;
    assign pix.last_pixel = last_pixel_reg;

    `MPS_ASSERT_ALWAYS(a_sp_bound, clk, rst_n, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer past depth")
    `MPS_ASSERT_ALWAYS(a_run_order, clk, rst_n, (state_reg != S_RUN) || (run_pos_reg <= run_end_reg), "run position past run end")
    `MPS_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(MAX_RESULTS), "pixel count past limit")
    `MPS_ASSERT_NEXT(a_last_idle, clk, rst_n, emit && last_beat, (state_reg == S_IDLE) && pix.valid && pix.last_pixel, "last pixel did not end the segment")
    `MPS_ASSERT_NEXT(a_pop_empty, clk, rst_n, stack_ctrl.pop, state_reg == S_POP, "pop without fetch cycle")

endmodule

### tb/sv/midpoint_subdivision_line_raster_core_tb.sv
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_raster_core_tb
// drives line segments into the raster core and checks every pixel beat
// against a typed run or an in-bench midpoint subdivision predictor; both
// channels stall at random, with one quiet stretch where neither side
// holds back
module midpoint_subdivision_line_raster_core_tb;

    localparam int COORD_BITS  = mps_pkg::COORD_BITS_DEF;
    localparam int STACK_DEPTH = mps_pkg::STACK_DEPTH_DEF;
    localparam int MAX_PIXELS  = 2 ** COORD_BITS;
    localparam int COORD_MAX   = MAX_PIXELS - 1;
    localparam int RANDOM_SEGS = 250;
    localparam int IDLE_PCT    = 14;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    // directed row; axis-aligned rows carry their run typed in
    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        bit     typed;
        coord_t run_x;
        coord_t run_y;
        bit     vert;
        int     count;
    } seg_case_t;

    logic clk = 1'b0;
    logic rst_n;

    mps_seg_if #(.COORD_BITS(COORD_BITS)) seg_ch ();
    mps_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    midpoint_subdivision_line_raster_core #(
        .COORD_BITS  (COORD_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_ch),
        .pix   (pix_ch)
    );

    pixel_t pixels_due[$];
    int     mismatches  = 0;
    int     pixels_seen = 0;
    int     runs_sent   = 0;
    int     splits_sent = 0;
    bit     no_idle     = 1'b0;

    seg_case_t directed_cases[22] = '{
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1'b1, 1},
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63, 1'b1, 1},
        '{6'd0,  6'd17, 6'd63, 6'd17, 1'b1, 6'd0,  6'd17, 1'b0, 64},
        '{6'd63, 6'd40, 6'd0,  6'd40, 1'b1, 6'd0,  6'd40, 1'b0, 64},
        '{6'd5,  6'd0,  6'd5,  6'd63, 1'b1, 6'd5,  6'd0,  1'b1, 64},
        '{6'd58, 6'd63, 6'd58, 6'd0,  1'b1, 6'd58, 6'd0,  1'b1, 64},
        '{6'd0,  6'd63, 6'd0,  6'd0,  1'b1, 6'd0,  6'd0,  1'b1, 64},
        '{6'd20, 6'd20, 6'd21, 6'd20, 1'b1, 6'd20, 6'd20, 1'b0, 2},
        '{6'd7,  6'd9,  6'd7,  6'd8,  1'b1, 6'd7,  6'd8,  1'b1, 2},
        '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd0,  6'd0,  6'd1,  6'd1,  1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd1,  6'd0,  6'd0,  6'd1,  1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd0,  6'd0,  6'd63, 6'd1,  1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd0,  6'd62, 6'd1,  6'd0,  1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd10, 6'd10, 6'd13, 6'd11, 1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd30, 6'd32, 6'd33, 6'd28, 1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd63, 6'd0,  6'd62, 6'd63, 1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd0,  6'd31, 6'd63, 6'd32, 1'b0, 6'd0,  6'd0,  1'b0, 0},
        '{6'd21, 6'd42, 6'd42, 6'd21, 1'b0, 6'd0,  6'd0,  1'b0, 0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void push_pixel(int x, int y);
        pixel_t p;
        p.x    = coord_t'(x);
        p.y    = coord_t'(y);
        p.last = 1'b0;
        pixels_due.push_back(p);
    endfunction

    function automatic void expect_run(coord_t x, coord_t y, bit vert, int count);
        for (int i = 0; i < count; i++)
        begin
            push_pixel(vert ? x : x + i, vert ? y + i : y);
        end
        pixels_due[pixels_due.size()-1].last = 1'b1;
    endfunction

    // midpoint subdivision with an explicit stack of pending right halves
    function automatic void rasterize_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        int  pend_ax[STACK_DEPTH];
        int  pend_ay[STACK_DEPTH];
        int  pend_bx[STACK_DEPTH];
        int  pend_by[STACK_DEPTH];
        int  cax, cay, cbx, cby;
        int  depth, emitted, pos, run_hi;
        int  lx, ly, rx, ry, sx, sy, lo, hi, top, bot;
        bit  vert, left_high;
        cax     = ax;
        cay     = ay;
        cbx     = bx;
        cby     = by;
        depth   = 0;
        emitted = 0;
        while (1)
        begin
            if (cax == cbx || cay == cby)
            begin
                vert   = (cax == cbx);
                lo     = vert ? cay : cax;
                hi     = vert ? cby : cbx;
                pos    = (lo < hi) ? lo : hi;
                run_hi = (lo < hi) ? hi : lo;
                while (emitted < MAX_PIXELS)
                begin
                    if (vert)
                        push_pixel(cax, pos);
                    else
                        push_pixel(pos, cay);
                    emitted++;
                    if (pos >= run_hi)
                        break;
                    pos++;
                end
                if (depth == 0 || emitted >= MAX_PIXELS)
                    break;
                depth--;
                cax = pend_ax[depth];
                cay = pend_ay[depth];
                cbx = pend_bx[depth];
                cby = pend_by[depth];
            end
            else
            begin
                if (cbx > cax)
                begin
                    lx = cax; ly = cay; rx = cbx; ry = cby;
                end
                else
                begin
                    lx = cbx; ly = cby; rx = cax; ry = cay;
                end
                left_high = (ly > ry);
                sx = lx + rx;
                lo = sx >> 1;
                hi = (sx + 1) >> 1;
                if (lo == hi)
                    hi++;
                sy  = cay + cby;
                bot = sy >> 1;
                top = (sy + 1) >> 1;
                // even sum: one row takes the exact midpoint, the other a row next to it
                if (top == bot)
                begin
                    if (left_high)
                        bot--;
                    else
                        top++;
                end
                // a right half that finds the stack full is dropped
                if (depth < STACK_DEPTH)
                begin
                    pend_ax[depth] = hi;
                    pend_ay[depth] = left_high ? bot : top;
                    pend_bx[depth] = rx;
                    pend_by[depth] = ry;
                    depth++;
                end
                cax = lx;
                cay = ly;
                cbx = lo;
                cby = left_high ? top : bot;
            end
        end
        pixels_due[pixels_due.size()-1].last = 1'b1;
    endfunction

    task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        while (idle_now())
        begin
            @(negedge clk);
            seg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= ax;
        seg_ch.start_y <= ay;
        seg_ch.end_x   <= bx;
        seg_ch.end_y   <= by;
        do
            @(posedge clk);
        while (seg_ch.ready !== 1'b1);
        if (ax == bx || ay == by)
            runs_sent++;
        else
            splits_sent++;
    endtask

    task automatic check_field(string name, coord_t want, coord_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        pix_ch.ready <= !idle_now();
    end

    // pixel beat checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
        begin
            if (pixels_due.size() == 0)
            begin
                $error("unexpected pixel beat x=%0d y=%0d last=%0b",
                       pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last_pixel);
                mismatches++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("pixel_x", want.x, pix_ch.pixel_x);
                check_field("pixel_y", want.y, pix_ch.pixel_y);
                check_field("last_pixel", coord_t'(want.last), coord_t'(pix_ch.last_pixel));
                pixels_seen++;
            end
        end
    end

    initial
    begin
        coord_t ax, ay, bx, by;
        int     pick, dx, dy;
        rst_n          = 1'b0;
        seg_ch.valid   = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x   = '0;
        seg_ch.end_y   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_cases[i])
        begin
            send_segment(directed_cases[i].sx, directed_cases[i].sy,
                         directed_cases[i].ex, directed_cases[i].ey);
            if (directed_cases[i].typed)
                expect_run(directed_cases[i].run_x, directed_cases[i].run_y,
                           directed_cases[i].vert, directed_cases[i].count);
            else
                rasterize_segment(directed_cases[i].sx, directed_cases[i].sy,
                                  directed_cases[i].ex, directed_cases[i].ey);
        end

        for (int n = 0; n < RANDOM_SEGS; n++)
        begin
            // quiet stretch: neither side stalls
            no_idle = (n >= 120 && n < 180);
            pick = $urandom_range(0, 99);
            ax = coord_t'($urandom_range(0, COORD_MAX));
            ay = coord_t'($urandom_range(0, COORD_MAX));
            bx = coord_t'($urandom_range(0, COORD_MAX));
            by = coord_t'($urandom_range(0, COORD_MAX));
            if (pick < 15)
                by = ay;
            else if (pick < 30)
                bx = ax;
            else if (pick < 37)
            begin
                bx = ax;
                by = ay;
            end
            else if (pick < 50)
            begin
                // short segment near the start point, clamped to the grid
                dx = int'(ax) + $urandom_range(0, 8) - 4;
                dy = int'(ay) + $urandom_range(0, 8) - 4;
                bx = coord_t'((dx < 0) ? 0 : (dx > COORD_MAX) ? COORD_MAX : dx);
                by = coord_t'((dy < 0) ? 0 : (dy > COORD_MAX) ? COORD_MAX : dy);
            end
            else if (pick < 58)
            begin
                ax = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
                ay = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
                bx = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
                by = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
            end
            send_segment(ax, ay, bx, by);
            rasterize_segment(ax, ay, bx, by);
        end
        no_idle = 1'b0;

        @(negedge clk);
        seg_ch.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        // let any stray beat show up
        repeat (32) @(posedge clk);

        $display("segments sent: %0d axis-aligned runs, %0d subdivided",
                 runs_sent, splits_sent);
        $display("pixel beats checked: %0d, mismatches: %0d", pixels_seen, mismatches);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $error("timeout with %0d pixel beats outstanding", pixels_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
